// ===== hdl/ihex_pkg.sv =====
// Shared types, constants and helper functions of the Intel HEX record encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ihex_pkg;

  // Data bytes per type 00 record, and the width that holds a count of them.
  localparam int LINE_BYTES = 16;
  localparam int LINE_W     = 8;

  // Command queue between the front and the back part.
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Configuration register indexes.
  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_TOTAL_LENGTH = 1'b1;

  // Fixed record fields.
  localparam logic [7:0]  TYPE_DATA       = 8'h00;
  localparam logic [7:0]  TYPE_EOF        = 8'h01;
  localparam logic [7:0]  TYPE_EXT_LINEAR = 8'h04;
  localparam logic [7:0]  TYPE_START      = 8'h05;
  localparam logic [7:0]  LEN_EXT_LINEAR  = 8'h02;
  localparam logic [7:0]  LEN_START       = 8'h04;
  localparam logic [7:0]  EOF_CHECKSUM    = 8'hFF;
  localparam logic [31:0] START_OFFSET    = 32'h0000_0189;

  // Record segments that the back part walks through for one word.
  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_EXT_FIRST,
    SEG_HEADER,
    SEG_DATA,
    SEG_CHECK,
    SEG_EXT_WRAP,
    SEG_START,
    SEG_EOF
  } seg_t;

  // Last byte index inside each segment.
  localparam logic [3:0] LAST_EXT    = 4'd6;
  localparam logic [3:0] LAST_HEADER = 4'd3;
  localparam logic [3:0] LAST_SINGLE = 4'd0;
  localparam logic [3:0] LAST_START  = 4'd8;
  localparam logic [3:0] LAST_EOF    = 4'd4;

  // One classified input word, as handed from front to back.
  typedef struct packed {
    logic [7:0]        data;
    logic              ext_first;
    logic [15:0]       up_first;
    logic              header;
    logic [LINE_W-1:0] len;
    logic [15:0]       offset;
    logic              close;
    logic [7:0]        checksum;
    logic              ext_wrap;
    logic [15:0]       up_wrap;
    logic              fin;
    logic [31:0]       start_addr;
  } cmd_t;

  function automatic logic [6:0] hex_digit(input logic [3:0] n);
    logic [6:0] d;
    if (n < 4'd10) begin
      d = 7'h30 + {3'b000, n};
    end else begin
      d = 7'h37 + {3'b000, n};
    end
    return d;
  endfunction

  function automatic seg_t first_seg(input cmd_t c);
    seg_t s;
    if (c.ext_first) begin
      s = SEG_EXT_FIRST;
    end else if (c.header) begin
      s = SEG_HEADER;
    end else begin
      s = SEG_DATA;
    end
    return s;
  endfunction

  // Segment that follows s for command c; SEG_IDLE once the word is done.
  function automatic seg_t next_seg(input cmd_t c, input seg_t s);
    seg_t n;
    case (s)
      SEG_EXT_FIRST: n = c.header ? SEG_HEADER : SEG_DATA;
      SEG_HEADER:    n = SEG_DATA;
      SEG_DATA:      n = c.close ? SEG_CHECK : SEG_IDLE;
      SEG_CHECK: begin
        if (c.ext_wrap) begin
          n = SEG_EXT_WRAP;
        end else if (c.fin) begin
          n = SEG_START;
        end else begin
          n = SEG_IDLE;
        end
      end
      SEG_EXT_WRAP:  n = c.fin ? SEG_START : SEG_IDLE;
      SEG_START:     n = SEG_EOF;
      default:       n = SEG_IDLE;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] seg_last(input seg_t s);
    logic [3:0] l;
    case (s)
      SEG_EXT_FIRST, SEG_EXT_WRAP: l = LAST_EXT;
      SEG_HEADER:                  l = LAST_HEADER;
      SEG_START:                   l = LAST_START;
      SEG_EOF:                     l = LAST_EOF;
      default:                     l = LAST_SINGLE;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ihex_front.sv =====
// Front part: configuration registers, image address state and classification
// of each data word into a record command. Depends on ihex_pkg.
`default_nettype none

module ihex_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  output ihex_pkg::cmd_t     cmd
);
  import ihex_pkg::*;

  logic [31:0]       base_address;
  logic [31:0]       total_length;
  logic [31:0]       bytes_left;
  logic [15:0]       offset_low;
  logic [15:0]       upper_address;
  logic [LINE_W-1:0] line_position;
  logic [7:0]        running_sum;
  logic              started;

  logic [31:0]       bl_cur;
  logic [15:0]       off_cur;
  logic [15:0]       up_cur;
  logic [LINE_W-1:0] lp_cur;
  logic [7:0]        sum_cur;
  logic              header;
  logic [LINE_W-1:0] len;
  logic [7:0]        sum_head;
  logic [7:0]        sum_data;
  logic [LINE_W-1:0] lp_data;
  logic              close;
  logic              fin;
  logic [15:0]       off_data;
  logic              wrap;
  logic [15:0]       up_inc;

  logic [31:0]       bytes_left_next;
  logic [15:0]       offset_low_next;
  logic [15:0]       upper_address_next;
  logic [LINE_W-1:0] line_position_next;
  logic [7:0]        running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      total_length <= 32'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_TOTAL_LENGTH: total_length <= cfg_data;
        default:          base_address <= base_address;
      endcase
    end
  end

  always_comb begin
    // a new image loads its counters from the registers
    bl_cur  = started ? bytes_left
                      : ((total_length == '0) ? 32'd1 : total_length);
    off_cur = started ? offset_low : base_address[15:0];
    up_cur  = started ? upper_address : base_address[31:16];
    lp_cur  = started ? line_position : '0;
    sum_cur = started ? running_sum : '0;

    header   = (lp_cur == '0);
    len      = (bl_cur < 32'(LINE_BYTES)) ? bl_cur[LINE_W-1:0] : LINE_W'(LINE_BYTES);
    sum_head = header ? (8'(len) + off_cur[15:8] + off_cur[7:0]) : sum_cur;
    sum_data = sum_head + data_byte;
    lp_data  = lp_cur + LINE_W'(1);
    bytes_left_next = bl_cur - 32'd1;
    fin      = (bytes_left_next == '0);
    close    = (lp_data >= LINE_W'(LINE_BYTES)) || fin;
    off_data = off_cur + 16'(lp_data);
    wrap     = close && (off_data == '0);
    up_inc   = up_cur + 16'd1;

    offset_low_next    = close ? off_data : off_cur;
    upper_address_next = wrap ? up_inc : up_cur;
    line_position_next = close ? '0 : lp_data;
    running_sum_next   = close ? '0 : sum_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      offset_low    <= '0;
      upper_address <= '0;
      line_position <= '0;
      running_sum   <= '0;
      started       <= 1'b0;
    end else if (accept) begin
      bytes_left    <= bytes_left_next;
      offset_low    <= offset_low_next;
      upper_address <= upper_address_next;
      line_position <= line_position_next;
      running_sum   <= running_sum_next;
      started       <= !fin;
    end
  end

  always_comb begin
    cmd.data       = data_byte;
    cmd.ext_first  = !started;
    cmd.up_first   = up_cur;
    cmd.header     = header;
    cmd.len        = len;
    cmd.offset     = off_cur;
    cmd.close      = close;
    cmd.checksum   = 8'd0 - sum_data;
    cmd.ext_wrap   = wrap;
    cmd.up_wrap    = up_inc;
    cmd.fin        = fin;
    cmd.start_addr = base_address + START_OFFSET;
  end

endmodule

`default_nettype wire

// ===== hdl/ihex_queue.sv =====
// Short command queue between front and back, held in flip-flops.
// Depends on ihex_pkg for cmd_t and the queue depth.
`default_nettype none

module ihex_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire ihex_pkg::cmd_t wr_data,
  output logic                full,
  output logic                rd_valid,
  output ihex_pkg::cmd_t      rd_data,
  input  wire logic           rd_pop
);
  import ihex_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ihex_back.sv =====
// Back part: walks the record segments of the head command into the output
// register, one record byte per cycle while pop frees it. Depends on ihex_pkg.
`default_nettype none

module ihex_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire ihex_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                empty,
  input  wire logic           pop,
  output logic [7:0]          record_byte,
  output logic [6:0]          ascii_high,
  output logic [6:0]          ascii_low,
  output logic                starts_record,
  output logic                ends_record,
  output logic                is_last
);
  import ihex_pkg::*;

  seg_t       seg;
  seg_t       seg_next;
  logic [3:0] idx;
  logic [3:0] idx_next;
  logic       out_valid;

  seg_t       cur_seg;
  seg_t       nseg;
  logic [3:0] cur_idx;
  logic       last_in_seg;
  logic       emit;
  logic       item_done;
  logic [15:0] ext_up;
  logic [7:0]  ext_sum;
  logic [7:0]  start_sum;
  logic [7:0]  byte_val;
  logic        starts_val;
  logic        ends_val;

  // a fresh command starts at its first segment without a bubble
  always_comb begin
    cur_seg     = (seg == SEG_IDLE) ? first_seg(cmd) : seg;
    cur_idx     = (seg == SEG_IDLE) ? 4'd0 : idx;
    last_in_seg = (cur_idx == seg_last(cur_seg));
    nseg        = next_seg(cmd, cur_seg);
    item_done   = last_in_seg && (nseg == SEG_IDLE);
    emit        = cmd_valid && (!out_valid || pop);
    cmd_pop     = emit && item_done;
  end

  always_comb begin
    seg_next = seg;
    idx_next = idx;
    if (emit) begin
      if (last_in_seg) begin
        seg_next = nseg;
        idx_next = '0;
      end else begin
        seg_next = cur_seg;
        idx_next = cur_idx + 4'd1;
      end
    end
  end

  always_comb begin
    ext_up    = (cur_seg == SEG_EXT_WRAP) ? cmd.up_wrap : cmd.up_first;
    ext_sum   = 8'd0 - (LEN_EXT_LINEAR + TYPE_EXT_LINEAR + ext_up[15:8] + ext_up[7:0]);
    start_sum = 8'd0 - (LEN_START + TYPE_START + cmd.start_addr[31:24]
                        + cmd.start_addr[23:16] + cmd.start_addr[15:8]
                        + cmd.start_addr[7:0]);
    byte_val  = 8'h00;
    case (cur_seg)
      SEG_EXT_FIRST, SEG_EXT_WRAP: begin
        case (cur_idx)
          4'd0:    byte_val = LEN_EXT_LINEAR;
          4'd3:    byte_val = TYPE_EXT_LINEAR;
          4'd4:    byte_val = ext_up[15:8];
          4'd5:    byte_val = ext_up[7:0];
          4'd6:    byte_val = ext_sum;
          default: byte_val = 8'h00;
        endcase
      end
      SEG_HEADER: begin
        case (cur_idx)
          4'd0:    byte_val = 8'(cmd.len);
          4'd1:    byte_val = cmd.offset[15:8];
          4'd2:    byte_val = cmd.offset[7:0];
          default: byte_val = TYPE_DATA;
        endcase
      end
      SEG_DATA:  byte_val = cmd.data;
      SEG_CHECK: byte_val = cmd.checksum;
      SEG_START: begin
        case (cur_idx)
          4'd0:    byte_val = LEN_START;
          4'd3:    byte_val = TYPE_START;
          4'd4:    byte_val = cmd.start_addr[31:24];
          4'd5:    byte_val = cmd.start_addr[23:16];
          4'd6:    byte_val = cmd.start_addr[15:8];
          4'd7:    byte_val = cmd.start_addr[7:0];
          4'd8:    byte_val = start_sum;
          default: byte_val = 8'h00;
        endcase
      end
      SEG_EOF: begin
        case (cur_idx)
          4'd3:    byte_val = TYPE_EOF;
          4'd4:    byte_val = EOF_CHECKSUM;
          default: byte_val = 8'h00;
        endcase
      end
      default: byte_val = 8'h00;
    endcase
    starts_val = (cur_idx == 4'd0) && (cur_seg inside {SEG_EXT_FIRST, SEG_EXT_WRAP,
                                                      SEG_HEADER, SEG_START, SEG_EOF});
    ends_val   = last_in_seg && (cur_seg inside {SEG_EXT_FIRST, SEG_EXT_WRAP,
                                                SEG_CHECK, SEG_START, SEG_EOF});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg       <= SEG_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      seg <= seg_next;
      idx <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      record_byte   <= byte_val;
      ascii_high    <= hex_digit(byte_val[7:4]);
      ascii_low     <= hex_digit(byte_val[3:0]);
      starts_record <= starts_val;
      ends_record   <= ends_val;
      is_last       <= item_done;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== hdl/intel_hex_record_encoder.sv =====
// Top level of the Intel HEX record encoder: front, command queue and back.
// Depends on ihex_pkg, ihex_front, ihex_queue and ihex_back.
//
//   channel   direction  handshake            words
//   -------   ---------  -------------------  ----------------------------------
//   config    in         cfg_write            cfg_index, cfg_data (32 bits)
//   input     in         push / full          data_byte
//   result    out        pop / empty          record_byte, ascii_high, ascii_low,
//                                             starts_record, ends_record, is_last
//
// The front takes one data word per cycle whenever the command queue has room,
// so full rises only after four words are waiting. The back emits one record
// byte per cycle while pop frees the output register: a data word yields 1 to 34 record
// bytes (1 in the body of a record, about 1.3 on average: 21 bytes per 16-byte record).
// A pushed word reaches the result through the queue entry and then the output register.
// rst is synchronous; it clears control state and sets base_address 0, total_length 1.
// A low pop holds the output register and, through it, the back and then the queue.
`default_nettype none

module intel_hex_record_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       record_byte,
  output logic [6:0]       ascii_high,
  output logic [6:0]       ascii_low,
  output logic             starts_record,
  output logic             ends_record,
  output logic             is_last
);
  import ihex_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;
  logic accept;

  // take a word only when the queue can hold its command
  assign accept = push && !full;

  ihex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (data_byte),
    .cmd       (front_cmd)
  );

  // decouple classification from byte emission
  ihex_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_valid (head_valid),
    .rd_data  (head_cmd),
    .rd_pop   (head_pop)
  );

  ihex_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (head_valid),
    .cmd           (head_cmd),
    .cmd_pop       (head_pop),
    .empty         (empty),
    .pop           (pop),
    .record_byte   (record_byte),
    .ascii_high    (ascii_high),
    .ascii_low     (ascii_low),
    .starts_record (starts_record),
    .ends_record   (ends_record),
    .is_last       (is_last)
  );

endmodule

`default_nettype wire
